// ===== sv/prct_pkg.sv =====
// ----------------------------------------------------------------------------
// Page reference count table package
// Beat types, command and status codes, and fixed widths shared by the
// table's modules.
// ----------------------------------------------------------------------------
package prct_pkg;

   localparam int unsigned PAGE_SHIFT  = 12;
   localparam int unsigned COUNT_WIDTH = 32;
   localparam int unsigned LIVE_WIDTH  = 11;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [1:0] CMD_GET   = 2'd0;
   localparam logic [1:0] CMD_REF   = 2'd1;
   localparam logic [1:0] CMD_UNREF = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_GROUP  = 2'd1;
   localparam logic [1:0] STATUS_DEC_ZERO  = 2'd2;
   localparam logic [1:0] STATUS_SATURATED = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] page_address;
   } req_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] ref_count;
      logic [1:0]             status;
      logic                   group_released;
   } rsp_type;

   typedef struct packed {
      logic                   count_we;
      logic [COUNT_WIDTH-1:0] count_new;
      logic                   live_we;
      logic [LIVE_WIDTH-1:0]  live_new;
      rsp_type                rsp;
   } update_type;

endpackage

// ===== sv/prct_ram.sv =====
// ----------------------------------------------------------------------------
// Page reference count table RAM
// Simple dual-port synchronous memory with one write port and one read
// port whose data is registered.
// ----------------------------------------------------------------------------
module prct_ram #(
   parameter int unsigned ADDR_BITS = 10,
   parameter int unsigned DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   localparam int unsigned DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/prct_clear.sv =====
// ----------------------------------------------------------------------------
// Page reference count table clearing sequencer
// After reset, walks every address of the tables once, one per cycle, so
// that both memories are written to zero before the first command.
// ----------------------------------------------------------------------------
module prct_clear #(
   parameter int unsigned ADDR_BITS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   output logic                 clearing,
   output logic [ADDR_BITS-1:0] clear_addr
);

   logic                 clearing_ff;
   logic                 clearing_in;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [ADDR_BITS-1:0] addr_in;

   always_comb begin
      addr_in     = addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         addr_in = addr_ff + 1'b1;
         if (addr_ff == {ADDR_BITS{1'b1}}) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         addr_ff     <= '0;
      end else begin
         clearing_ff <= clearing_in;
         addr_ff     <= addr_in;
      end
   end

   assign clearing   = clearing_ff;
   assign clear_addr = addr_ff;

endmodule

// ===== sv/prct_update.sv =====
// ----------------------------------------------------------------------------
// Page reference count table update logic
// Works out the new page count, the new live-entry count of the group,
// their write enables and the result beat from the values read.
// ----------------------------------------------------------------------------
module prct_update
   import prct_pkg::*;
(
   input  logic [1:0]             cmd,
   input  logic [COUNT_WIDTH-1:0] count,
   input  logic [LIVE_WIDTH-1:0]  live,
   output update_type             upd
);

   logic [COUNT_WIDTH-1:0] count_inc;
   logic [COUNT_WIDTH-1:0] count_dec;
   logic [LIVE_WIDTH-1:0]  live_inc;
   logic [LIVE_WIDTH-1:0]  live_dec;

   assign count_inc = count + 1'b1;
   assign count_dec = count - 1'b1;
   assign live_inc  = live + 1'b1;
   assign live_dec  = live - 1'b1;

   always_comb begin
      upd                    = '0;
      upd.count_new          = count;
      upd.live_new           = live;
      upd.rsp.ref_count      = count;
      upd.rsp.status         = STATUS_OK;
      upd.rsp.group_released = 1'b0;
      unique case (cmd)
         CMD_REF: begin
            if (count == COUNT_MAX) begin
               upd.rsp.status = STATUS_SATURATED;
            end else begin
               upd.count_we      = 1'b1;
               upd.count_new     = count_inc;
               upd.rsp.ref_count = count_inc;
               if (count == '0) begin
                  upd.live_we  = 1'b1;
                  upd.live_new = live_inc;
               end
            end
         end
         CMD_UNREF: begin
            if (live == '0) begin
               upd.rsp.status    = STATUS_NO_GROUP;
               upd.rsp.ref_count = '0;
            end else if (count == '0) begin
               upd.rsp.status = STATUS_DEC_ZERO;
            end else begin
               upd.count_we      = 1'b1;
               upd.count_new     = count_dec;
               upd.rsp.ref_count = count_dec;
               if (count_dec == '0) begin
                  upd.live_we            = 1'b1;
                  upd.live_new           = live_dec;
                  upd.rsp.group_released = (live_dec == '0);
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== sv/page_reference_count_table_unit.sv =====
// ----------------------------------------------------------------------------
// Page reference count table unit
// An accepted request beat reads both memories; the update stage then
// registers its response beat. No new request is taken while an update
// is in progress: the memory read and the write back of the same entry are
// interlocked, one command at a time. After reset, both tables are cleared,
// during which no request is accepted.
// ----------------------------------------------------------------------------
module page_reference_count_table_unit
   import prct_pkg::*;
#(
   parameter int unsigned GROUP_BITS = 10,
   parameter int unsigned ENTRY_BITS = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned SLOT_BITS = GROUP_BITS + ENTRY_BITS;

   logic                   clearing;
   logic [SLOT_BITS-1:0]   clear_addr;
   logic                   req_accept;
   logic [GROUP_BITS-1:0]  req_group;
   logic [ENTRY_BITS-1:0]  req_entry;

   logic                   busy_ff;
   logic [1:0]             cmd_ff;
   logic [GROUP_BITS-1:0]  group_ff;
   logic [ENTRY_BITS-1:0]  entry_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_data_ff;

   logic [COUNT_WIDTH-1:0] count_rd;
   logic [LIVE_WIDTH-1:0]  live_rd;
   update_type             upd;

   logic                   count_wr_en;
   logic [SLOT_BITS-1:0]   count_wr_addr;
   logic [COUNT_WIDTH-1:0] count_wr_data;
   logic                   live_wr_en;
   logic [GROUP_BITS-1:0]  live_wr_addr;
   logic [LIVE_WIDTH-1:0]  live_wr_data;

   assign req_stall  = clearing | busy_ff | (rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;
   assign req_entry  = req_data.page_address[PAGE_SHIFT +: ENTRY_BITS];
   assign req_group  = req_data.page_address[PAGE_SHIFT + ENTRY_BITS +: GROUP_BITS];

   prct_clear #(
      .ADDR_BITS(SLOT_BITS)
   ) u_clear (
      .clock      (clock),
      .reset      (reset),
      .clearing   (clearing),
      .clear_addr (clear_addr)
   );

   assign count_wr_en   = clearing | (busy_ff & upd.count_we);
   assign count_wr_addr = clearing ? clear_addr : {group_ff, entry_ff};
   assign count_wr_data = clearing ? '0 : upd.count_new;
   assign live_wr_en    = clearing | (busy_ff & upd.live_we);
   assign live_wr_addr  = clearing ? clear_addr[GROUP_BITS-1:0] : group_ff;
   assign live_wr_data  = clearing ? '0 : upd.live_new;

   prct_ram #(
      .ADDR_BITS(SLOT_BITS),
      .DATA_BITS(COUNT_WIDTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (count_wr_en),
      .wr_addr (count_wr_addr),
      .wr_data (count_wr_data),
      .rd_en   (req_accept),
      .rd_addr ({req_group, req_entry}),
      .rd_data (count_rd)
   );

   prct_ram #(
      .ADDR_BITS(GROUP_BITS),
      .DATA_BITS(LIVE_WIDTH)
   ) u_live_ram (
      .clock   (clock),
      .wr_en   (live_wr_en),
      .wr_addr (live_wr_addr),
      .wr_data (live_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_group),
      .rd_data (live_rd)
   );

   prct_update u_update (
      .cmd   (cmd_ff),
      .count (count_rd),
      .live  (live_rd),
      .upd   (upd)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (busy_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= req_accept;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_data.cmd;
         group_ff <= req_group;
         entry_ff <= req_entry;
      end
      if (busy_ff) begin
         rsp_data_ff <= upd.rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_accept_while_clearing : assert property (
      @(posedge clock) disable iff (reset) req_accept |-> !clearing
   ) else $error("request accepted while the tables are being cleared");

   a_busy_after_accept : assert property (
      @(posedge clock) disable iff (reset) req_accept |=> busy_ff
   ) else $error("accepted request did not enter the update stage");

   a_rsp_free_during_update : assert property (
      @(posedge clock) disable iff (reset) busy_ff |-> !rsp_valid_ff
   ) else $error("response register still full while an update completes");

   a_rsp_after_update : assert property (
      @(posedge clock) disable iff (reset) busy_ff |=> rsp_valid_ff
   ) else $error("update completed without a response beat");

   a_error_count_zero : assert property (
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && (rsp_data_ff.status == STATUS_NO_GROUP ||
                           rsp_data_ff.status == STATUS_DEC_ZERO))
         |-> (rsp_data_ff.ref_count == '0 && !rsp_data_ff.group_released)
   ) else $error("error response with a non-zero count or a release");

endmodule
